// ----- rtl/lpg_pkg.sv -----
// Shared types, codes and constants for the LED pattern generator.
`default_nettype none
package lpg_pkg;

    localparam int ElapsedW = 32;
    localparam int PeriodW  = 16;
    localparam int LevelW   = 12;
    localparam int SpanW    = 12;
    localparam int ProdW    = ElapsedW + SpanW;
    localparam int DivCntW  = $clog2(ProdW);
    localparam int StepW    = LevelW + 1;

    localparam logic [LevelW-1:0] BREATHE_TOP_RESET    = 12'd2700;
    localparam logic [LevelW-1:0] BREATHE_BOTTOM_RESET = 12'd1750;
    localparam logic [PeriodW-1:0] TALK_PERIOD_RESET    = 16'd100;
    localparam logic [PeriodW-1:0] BATTERY_PERIOD_RESET = 16'd100;
    localparam logic [PeriodW-1:0] BREATHE_PERIOD_RESET = 16'd1000;

    localparam logic [2:0] MODE_TALK    = 3'd0;
    localparam logic [2:0] MODE_BLINK   = 3'd1;
    localparam logic [2:0] MODE_FIXED   = 3'd2;
    localparam logic [2:0] MODE_BREATHE = 3'd3;
    localparam logic [2:0] MODE_BATTERY = 3'd4;

    localparam logic [2:0] REG_MODE           = 3'd0;
    localparam logic [2:0] REG_MODE_PARAM     = 3'd1;
    localparam logic [2:0] REG_TALK_PERIOD    = 3'd2;
    localparam logic [2:0] REG_BATTERY_PERIOD = 3'd3;
    localparam logic [2:0] REG_BREATHE_PERIOD = 3'd4;
    localparam logic [2:0] REG_BREATHE_TOP    = 3'd5;
    localparam logic [2:0] REG_BREATHE_BOTTOM = 3'd6;

    localparam logic OP_TICK = 1'b0;
    localparam logic OP_LOAD = 1'b1;

    localparam logic [1:0] WK_NONE    = 2'd0;
    localparam logic [1:0] WK_DIGITAL = 2'd1;
    localparam logic [1:0] WK_ANALOG  = 2'd2;

    typedef enum logic [1:0] {
        LVL_LOW,
        LVL_HIGH,
        LVL_UNKNOWN
    } level_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_START,
        ST_DIV,
        ST_APPLY,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic               start;
        logic [ProdW-1:0]   dividend;
        logic [PeriodW-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [ProdW-1:0] quotient;
    } div_rsp_t;

endpackage
`default_nettype wire

// ----- rtl/lpg_div.sv -----
// Restoring divider that produces one quotient bit per cycle.
`default_nettype none
module lpg_div (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire lpg_pkg::div_req_t req,
    output lpg_pkg::div_rsp_t     rsp
);

    logic [lpg_pkg::ProdW-1:0]   quo_reg, quo_next;
    logic [lpg_pkg::PeriodW-1:0] rem_reg, rem_next;
    logic [lpg_pkg::PeriodW-1:0] dvs_reg, dvs_next;
    logic [lpg_pkg::DivCntW-1:0] cnt_reg, cnt_next;
    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;
    logic [lpg_pkg::PeriodW:0]   rem_shift;
    logic                        fits;

    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[lpg_pkg::ProdW-1]};
        fits      = rem_shift >= {1'b0, dvs_reg};
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = done_reg;
        if (req.start)
        begin
            quo_next  = req.dividend;
            rem_next  = '0;
            dvs_next  = req.divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
            done_next = 1'b0;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[lpg_pkg::ProdW-2:0], fits};
            rem_next = fits ? lpg_pkg::PeriodW'(rem_shift - {1'b0, dvs_reg})
                            : rem_shift[lpg_pkg::PeriodW-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == lpg_pkg::DivCntW'(lpg_pkg::ProdW - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule
`default_nettype wire

// ----- rtl/led_pattern_generator_unit.sv -----
// Top level of the LED pattern generator: registers, sequencer and result stage.
//
//   Channel  Signals                               Direction  Handshake
//   in       operation, talk_count                 in         in_valid / in_stall
//   out      write_kind, drive_value               out        out_valid / out_stall
//   cfg      cfg_index, cfg_data                   in         cfg_valid / cfg_ready
//
// A load request or a tick outside breathe mode reaches the result register in the
// cycle after acceptance. A breathe tick passes the multiply, start, divide and apply
// states; the 44-step serial divider forms elapsed*(top-bottom)/period.
// One request is in work at a time; in_stall is high from acceptance until the
// result has moved into the output register, which then waits for out_stall low.
// Reset loads the register defaults and returns all pattern state to its start values at once.
`default_nettype none
module led_pattern_generator_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        operation,
    input  wire logic [15:0] talk_count,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [1:0]       write_kind,
    output logic [11:0]      drive_value,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    lpg_pkg::state_t state_reg, state_next;

    logic [2:0]                   mode_reg;
    logic [lpg_pkg::PeriodW-1:0]  mode_param_reg;
    logic [lpg_pkg::PeriodW-1:0]  talk_period_reg;
    logic [lpg_pkg::PeriodW-1:0]  battery_period_reg;
    logic [lpg_pkg::PeriodW-1:0]  breathe_period_reg;
    logic [lpg_pkg::LevelW-1:0]   breathe_top_reg;
    logic [lpg_pkg::LevelW-1:0]   breathe_bottom_reg;

    logic [lpg_pkg::ElapsedW-1:0] elapsed_reg, elapsed_next;
    logic [lpg_pkg::PeriodW-1:0]  toggles_reg, toggles_next;
    lpg_pkg::level_t              pin_reg, pin_next;
    logic [lpg_pkg::LevelW-1:0]   level_reg, level_next;
    logic                         rising_reg, rising_next;

    logic [lpg_pkg::ProdW-1:0]    product_reg, product_next;
    logic [1:0]                   res_kind_reg, res_kind_next;
    logic [lpg_pkg::LevelW-1:0]   res_value_reg, res_value_next;

    logic                         out_valid_reg, out_valid_next;
    logic [1:0]                   out_kind_reg, out_kind_next;
    logic [lpg_pkg::LevelW-1:0]   out_value_reg, out_value_next;

    lpg_pkg::div_req_t div_req;
    lpg_pkg::div_rsp_t div_rsp;

    logic                         accept;
    logic                         load_out;
    logic [lpg_pkg::ElapsedW-1:0] elapsed_inc;
    logic                         period_hit;
    lpg_pkg::level_t              pin_toggled;
    lpg_pkg::level_t              pin_want;
    logic [lpg_pkg::SpanW-1:0]    span;
    logic [lpg_pkg::PeriodW-1:0]  divisor;
    logic [lpg_pkg::StepW-1:0]    step;
    logic [lpg_pkg::StepW:0]      level_sum;
    logic [lpg_pkg::StepW:0]      bottom_sum;
    logic [lpg_pkg::LevelW-1:0]   level_new;
    logic [lpg_pkg::PeriodW-1:0]  toggles_dec;

    lpg_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Next-state logic of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lpg_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (operation == lpg_pkg::OP_TICK && mode_reg == lpg_pkg::MODE_BREATHE)
                        state_next = lpg_pkg::ST_MUL;
                    else
                        state_next = lpg_pkg::ST_OUT;
                end
            end
            lpg_pkg::ST_MUL:   state_next = lpg_pkg::ST_START;
            lpg_pkg::ST_START: state_next = lpg_pkg::ST_DIV;
            lpg_pkg::ST_DIV:
            begin
                if (div_rsp.done)
                    state_next = lpg_pkg::ST_APPLY;
            end
            lpg_pkg::ST_APPLY: state_next = lpg_pkg::ST_OUT;
            lpg_pkg::ST_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                    state_next = lpg_pkg::ST_IDLE;
            end
            default:           state_next = lpg_pkg::ST_IDLE;
        endcase
    end

    // Control outputs of the sequencer.
    always_comb
    begin
        in_stall         = 1'b1;
        div_req.start    = 1'b0;
        div_req.dividend = product_reg;
        div_req.divisor  = divisor;
        load_out         = 1'b0;
        case (state_reg)
            lpg_pkg::ST_IDLE:  in_stall = 1'b0;
            lpg_pkg::ST_START: div_req.start = 1'b1;
            lpg_pkg::ST_OUT:   load_out = !out_valid_reg || !out_stall;
            default:           in_stall = 1'b1;
        endcase
    end

    assign accept           = in_valid && !in_stall;
    assign cfg_ready        = 1'b1;

    always_comb
    begin
        elapsed_inc = (elapsed_reg == '1) ? elapsed_reg : elapsed_reg + 1'b1;
        pin_toggled = (pin_reg == lpg_pkg::LVL_LOW) ? lpg_pkg::LVL_HIGH : lpg_pkg::LVL_LOW;
        pin_want    = (mode_param_reg != '0) ? lpg_pkg::LVL_HIGH : lpg_pkg::LVL_LOW;
        span        = (breathe_top_reg > breathe_bottom_reg)
                      ? breathe_top_reg - breathe_bottom_reg : '0;
        divisor     = (breathe_period_reg == '0) ? lpg_pkg::PeriodW'(1) : breathe_period_reg;
        toggles_dec = toggles_reg - 1'b1;
        case (mode_reg)
            lpg_pkg::MODE_TALK:    period_hit = elapsed_inc > {16'd0, talk_period_reg};
            lpg_pkg::MODE_BLINK:   period_hit = elapsed_inc > {16'd0, mode_param_reg};
            lpg_pkg::MODE_BATTERY: period_hit = elapsed_inc > {16'd0, battery_period_reg};
            default:               period_hit = 1'b0;
        endcase

        // Steps of 4096 or more reach either bound, so the step saturates there.
        step = (div_rsp.quotient[lpg_pkg::ProdW-1:lpg_pkg::LevelW] != '0)
               ? lpg_pkg::StepW'(1 << lpg_pkg::LevelW)
               : {1'b0, div_rsp.quotient[lpg_pkg::LevelW-1:0]};
        level_sum  = {2'b00, level_reg} + {1'b0, step};
        bottom_sum = {2'b00, breathe_bottom_reg} + {1'b0, step};
        if (rising_reg)
            level_new = (level_sum > {2'b00, breathe_top_reg})
                        ? breathe_top_reg : level_sum[lpg_pkg::LevelW-1:0];
        else
            level_new = ({2'b00, level_reg} >= bottom_sum)
                        ? lpg_pkg::LevelW'(level_reg - step[lpg_pkg::LevelW-1:0])
                        : breathe_bottom_reg;
    end

    // Pattern state and result datapath.
    always_comb
    begin
        elapsed_next   = elapsed_reg;
        toggles_next   = toggles_reg;
        pin_next       = pin_reg;
        level_next     = level_reg;
        rising_next    = rising_reg;
        product_next   = product_reg;
        res_kind_next  = res_kind_reg;
        res_value_next = res_value_reg;
        out_valid_next = out_valid_reg;
        out_kind_next  = out_kind_reg;
        out_value_next = out_value_reg;

        if (accept)
        begin
            res_kind_next  = lpg_pkg::WK_NONE;
            res_value_next = '0;
            if (operation == lpg_pkg::OP_LOAD)
            begin
                toggles_next = talk_count;
            end
            else
            begin
                elapsed_next = elapsed_inc;
                case (mode_reg)
                    lpg_pkg::MODE_TALK:
                    begin
                        if (toggles_reg != '0 && period_hit)
                        begin
                            pin_next       = pin_toggled;
                            elapsed_next   = '0;
                            toggles_next   = toggles_dec;
                            res_kind_next  = lpg_pkg::WK_DIGITAL;
                            res_value_next = {11'd0, pin_toggled == lpg_pkg::LVL_HIGH};
                        end
                        if (toggles_reg == '0 || (period_hit && toggles_dec == '0))
                        begin
                            pin_next       = lpg_pkg::LVL_LOW;
                            res_kind_next  = lpg_pkg::WK_DIGITAL;
                            res_value_next = '0;
                        end
                    end
                    lpg_pkg::MODE_BLINK, lpg_pkg::MODE_BATTERY:
                    begin
                        if (period_hit)
                        begin
                            pin_next       = pin_toggled;
                            elapsed_next   = '0;
                            res_kind_next  = lpg_pkg::WK_DIGITAL;
                            res_value_next = {11'd0, pin_toggled == lpg_pkg::LVL_HIGH};
                        end
                    end
                    lpg_pkg::MODE_FIXED:
                    begin
                        if (pin_reg != pin_want)
                        begin
                            pin_next       = pin_want;
                            res_kind_next  = lpg_pkg::WK_DIGITAL;
                            res_value_next = {11'd0, pin_want == lpg_pkg::LVL_HIGH};
                        end
                    end
                    lpg_pkg::MODE_BREATHE:
                    begin
                        pin_next = lpg_pkg::LVL_UNKNOWN;
                    end
                    default:
                    begin
                        pin_next = pin_reg;
                    end
                endcase
            end
        end

        if (state_reg == lpg_pkg::ST_MUL)
            product_next = elapsed_reg * span;

        if (state_reg == lpg_pkg::ST_APPLY && step != '0)
        begin
            level_next     = level_new;
            elapsed_next   = '0;
            res_kind_next  = lpg_pkg::WK_ANALOG;
            res_value_next = level_new;
            if (rising_reg && level_new == breathe_top_reg)
                rising_next = 1'b0;
            if (!rising_reg && level_new == breathe_bottom_reg)
                rising_next = 1'b1;
        end

        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
        if (load_out)
        begin
            out_valid_next = 1'b1;
            out_kind_next  = res_kind_reg;
            out_value_next = res_value_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= lpg_pkg::ST_IDLE;
            mode_reg           <= lpg_pkg::MODE_BREATHE;
            mode_param_reg     <= '0;
            talk_period_reg    <= lpg_pkg::TALK_PERIOD_RESET;
            battery_period_reg <= lpg_pkg::BATTERY_PERIOD_RESET;
            breathe_period_reg <= lpg_pkg::BREATHE_PERIOD_RESET;
            breathe_top_reg    <= lpg_pkg::BREATHE_TOP_RESET;
            breathe_bottom_reg <= lpg_pkg::BREATHE_BOTTOM_RESET;
            elapsed_reg        <= '0;
            toggles_reg        <= '0;
            pin_reg            <= lpg_pkg::LVL_LOW;
            level_reg          <= lpg_pkg::BREATHE_BOTTOM_RESET;
            rising_reg         <= 1'b1;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            elapsed_reg   <= elapsed_next;
            toggles_reg   <= toggles_next;
            pin_reg       <= pin_next;
            level_reg     <= level_next;
            rising_reg    <= rising_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    lpg_pkg::REG_MODE:           mode_reg           <= cfg_data[2:0];
                    lpg_pkg::REG_MODE_PARAM:     mode_param_reg     <= cfg_data;
                    lpg_pkg::REG_TALK_PERIOD:    talk_period_reg    <= cfg_data;
                    lpg_pkg::REG_BATTERY_PERIOD: battery_period_reg <= cfg_data;
                    lpg_pkg::REG_BREATHE_PERIOD: breathe_period_reg <= cfg_data;
                    lpg_pkg::REG_BREATHE_TOP:    breathe_top_reg    <= cfg_data[11:0];
                    lpg_pkg::REG_BREATHE_BOTTOM: breathe_bottom_reg <= cfg_data[11:0];
                    default:                     mode_reg           <= mode_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        product_reg   <= product_next;
        res_kind_reg  <= res_kind_next;
        res_value_reg <= res_value_next;
        out_kind_reg  <= out_kind_next;
        out_value_reg <= out_value_next;
    end

    assign out_valid   = out_valid_reg;
    assign write_kind  = out_kind_reg;
    assign drive_value = out_value_reg;

endmodule
`default_nettype wire

// ----- rtl/lpg_checker.sv -----
// Port-level assertions for the LED pattern generator and their binding.
`default_nettype none
module lpg_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_stall,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [1:0]  write_kind,
    input wire logic [11:0] drive_value
);

    a_kind_known: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (write_kind == lpg_pkg::WK_NONE || write_kind == lpg_pkg::WK_DIGITAL
                       || write_kind == lpg_pkg::WK_ANALOG))
        else $error("Result carries an unknown write kind.");

    a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && write_kind == lpg_pkg::WK_NONE |-> drive_value == 12'd0)
        else $error("Result without a pin write carries a nonzero value.");

    a_digital_bit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && write_kind == lpg_pkg::WK_DIGITAL |-> drive_value[11:1] == 11'd0)
        else $error("Digital write carries a level other than 0 or 1.");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("A new request was taken while one was in work.");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(write_kind) && $stable(drive_value))
        else $error("Stalled result changed or dropped.");

endmodule

bind led_pattern_generator_unit lpg_checker u_lpg_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .write_kind  (write_kind),
    .drive_value (drive_value)
);
`default_nettype wire
